[hdl/lsch_pkg.sv]
// ----------------------------------------------------------------------------
// lsch_pkg
// Shared types, constants and register codes for the lottery scheduler.
// ----------------------------------------------------------------------------
`default_nettype none

package lsch_pkg;

  localparam int SLOTS_DEFAULT = 16;
  localparam int BURST_W       = 16;
  localparam int TICK_W        = 16;
  localparam int RAND_W        = 32;
  localparam int SLOT_W        = 4;
  localparam int CFG_IDX_W     = 1;
  localparam int CFG_DATA_W    = 16;
  localparam int DIV_STEPS     = BURST_W;

  localparam logic [BURST_W-1:0] QUANTUM_RESET = 16'd20;
  localparam logic [BURST_W-1:0] DIVISOR_RESET = 16'd20;

  localparam logic [CFG_IDX_W-1:0] REG_QUANTUM = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_DIVISOR = 1'b1;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_DRAW = 1'b1;

  typedef struct packed {
    logic               operation;
    logic [SLOT_W-1:0]  slot;
    logic [BURST_W-1:0] burst;
    logic [RAND_W-1:0]  random_value;
  } in_item_t;

  typedef struct packed {
    logic [SLOT_W-1:0]  winner_slot;
    logic [BURST_W-1:0] winner_burst_left;
    logic               granted;
    logic               all_done;
  } out_item_t;

  // Control broadcast from the sequencer to every cell of the row.
  typedef struct packed {
    logic div_start;
    logic div_step;
    logic tick_fix;
    logic rotate;
  } cell_ctl_t;

endpackage

`default_nettype wire

[hdl/lsch_cell.sv]
// ----------------------------------------------------------------------------
// lsch_cell
// One process slot: burst count, bit-serial ticket divider, ring stage.
// ----------------------------------------------------------------------------
`default_nettype none

module lsch_cell (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire lsch_pkg::cell_ctl_t       ctl,
  input  wire logic [lsch_pkg::BURST_W-1:0] divisor,
  input  wire logic                      load_en,
  input  wire logic [lsch_pkg::BURST_W-1:0] load_data,
  input  wire logic [lsch_pkg::BURST_W-1:0] burst_in,
  input  wire logic [lsch_pkg::TICK_W-1:0]  tick_in,
  output logic [lsch_pkg::BURST_W-1:0]   burst_out,
  output logic [lsch_pkg::TICK_W-1:0]    tick_out,
  output logic                           nonzero
);
  import lsch_pkg::*;

  logic [BURST_W-1:0] burst;
  logic [TICK_W-1:0]  tick;
  logic [BURST_W-1:0] rem;
  logic [BURST_W:0]   trial;
  logic [BURST_W:0]   diff;
  logic               qbit;
  logic [BURST_W-1:0] rem_next;

  // Restoring division step: shift in the next dividend bit from tick.
  assign trial    = {rem, tick[TICK_W-1]};
  assign diff     = trial - {1'b0, divisor};
  assign qbit     = ~diff[BURST_W];
  assign rem_next = qbit ? diff[BURST_W-1:0] : trial[BURST_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      burst <= '0;
    end else if (load_en) begin
      burst <= load_data;
    end else if (ctl.rotate) begin
      burst <= burst_in;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.div_start) begin
      rem  <= '0;
      tick <= burst;
    end else if (ctl.div_step) begin
      rem  <= rem_next;
      tick <= {tick[TICK_W-2:0], qbit};
    end else if (ctl.tick_fix) begin
      // empty slot holds no ticket, a live slot at least one
      if (burst == '0) begin
        tick <= '0;
      end else if (tick == '0) begin
        tick <= TICK_W'(1);
      end
    end else if (ctl.rotate) begin
      tick <= tick_in;
    end
  end

  assign burst_out = burst;
  assign tick_out  = tick;
  assign nonzero   = (burst != '0);

endmodule

`default_nettype wire

[hdl/lsch_mod.sv]
// ----------------------------------------------------------------------------
// lsch_mod
// Iterative remainder unit: one restoring step per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module lsch_mod #(
  parameter int NUM_W = 32,
  parameter int DEN_W = 20
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [NUM_W-1:0] num,
  input  wire logic [DEN_W-1:0] den,
  output logic                  done,
  output logic [DEN_W-1:0]      rem
);
  import lsch_pkg::*;

  localparam int CW = $clog2(NUM_W);

  logic             busy;
  logic [CW-1:0]    cnt;
  logic [NUM_W-1:0] num_sh;
  logic [DEN_W-1:0] den_q;
  logic [DEN_W:0]   trial;
  logic [DEN_W+1:0] diff;

  assign trial = {rem, num_sh[NUM_W-1]};
  assign diff  = {1'b0, trial} - {2'b00, den_q};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + CW'(1);
        if (cnt == CW'(NUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem    <= '0;
      num_sh <= num;
      den_q  <= den;
    end else if (busy) begin
      num_sh <= {num_sh[NUM_W-2:0], 1'b0};
      rem    <= diff[DEN_W+1] ? trial[DEN_W-1:0] : diff[DEN_W-1:0];
    end
  end

endmodule

`default_nettype wire

[hdl/lottery_scheduler_core.sv]
// ----------------------------------------------------------------------------
// lottery_scheduler_core
// Lottery scheduler over a row of slot cells with a serial remainder unit.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake             Payload
// in        in         in_valid / in_stall   in_data   (lsch_pkg::in_item_t)
// out       out        out_valid / out_stall out_data  (lsch_pkg::out_item_t)
// cfg       in         cfg_write_en          cfg_index, cfg_data
//
// A load transfer goes straight to the result stage. A draw runs 16 divider
// steps in every cell at once, then the tickets go around the cell ring
// twice (sum pass, search pass) with the 32-step remainder unit between the
// passes; a draw with no tickets ends after the sum pass.
// Reset is synchronous and clears all slot bursts, the config registers and the control state.
// One item is in work at a time; the result register lets the next item in
// while a finished result waits on out_stall.
// ----------------------------------------------------------------------------
`default_nettype none

module lottery_scheduler_core #(
  parameter int SLOTS = lsch_pkg::SLOTS_DEFAULT
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire lsch_pkg::in_item_t            in_data,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output lsch_pkg::out_item_t                out_data,
  input  wire logic                          cfg_write_en,
  input  wire logic [lsch_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [lsch_pkg::CFG_DATA_W-1:0] cfg_data
);
  import lsch_pkg::*;

  localparam int SW   = $clog2(SLOTS);
  localparam int TW   = TICK_W + SW;
  localparam int CNTW = (SW + 1 > 4) ? SW + 1 : 4;

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_DIV  = 8'b0000_0010,
    S_FIX  = 8'b0000_0100,
    S_SUM  = 8'b0000_1000,
    S_MOD  = 8'b0001_0000,
    S_WALK = 8'b0010_0000,
    S_UPD  = 8'b0100_0000,
    S_OUT  = 8'b1000_0000
  } state_t;

  state_t state, state_next;

  logic [BURST_W-1:0] quantum;
  logic [BURST_W-1:0] ticket_divisor;
  logic [BURST_W-1:0] div_eff;

  logic [CNTW-1:0]    cnt;
  logic [TW-1:0]      acc;
  logic [TW-1:0]      tick_ext;
  logic [TW-1:0]      total_next;
  logic [TW:0]        range_end;
  logic [RAND_W-1:0]  rnd;
  logic [TW-1:0]      win;
  logic               mod_done;
  logic               mod_start;
  logic               found;
  logic               hit;
  logic [SW-1:0]      chosen;
  logic [BURST_W-1:0] chosen_burst;
  logic [BURST_W-1:0] new_burst;
  logic               res_granted;
  logic [SW+3:0]      slot_wide;

  logic in_fire;
  logic out_load;
  cell_ctl_t ctl;

  logic [BURST_W-1:0] burst_ring [SLOTS];
  logic [TICK_W-1:0]  tick_ring  [SLOTS];
  logic [SLOTS-1:0]   nz;

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk) begin
    if (rst) begin
      quantum        <= QUANTUM_RESET;
      ticket_divisor <= DIVISOR_RESET;
    end else if (cfg_write_en) begin
      case (cfg_index)
        REG_QUANTUM: quantum        <= cfg_data;
        REG_DIVISOR: ticket_divisor <= cfg_data;
        default: ;
      endcase
    end
  end

  // a zero divisor counts as one
  assign div_eff = (ticket_divisor == '0) ? BURST_W'(1) : ticket_divisor;

  // ------------------------------------------------------------ handshakes
  assign in_stall = (state != S_IDLE);
  assign in_fire  = in_valid & ~in_stall;
  assign out_load = (state == S_OUT) & (~out_valid | ~out_stall);

  // -------------------------------------------------------- cell controls
  always_comb begin
    ctl           = '0;
    ctl.div_start = in_fire & (in_data.operation == OP_DRAW);
    ctl.div_step  = (state == S_DIV);
    ctl.tick_fix  = (state == S_FIX);
    ctl.rotate    = (state == S_SUM) | (state == S_WALK);
  end

  // Cell 0 is the ring head: at step k of a pass it shows slot k's burst and tickets.
  assign tick_ext   = TW'(tick_ring[0]);
  assign total_next = acc + tick_ext;
  assign range_end  = {1'b0, acc} + {1'b0, tick_ext};
  assign hit        = ~found & (tick_ring[0] != '0) & ({1'b0, win} < range_end);
  assign mod_start  = (state == S_SUM) & (cnt == CNTW'(SLOTS - 1)) &
                      (total_next != '0);

  assign new_burst = (chosen_burst > quantum) ? chosen_burst - quantum : '0;

  // ------------------------------------------------------------- cell row
  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    logic                load_en;
    logic [BURST_W-1:0]  load_data;

    assign load_en = (in_fire & (in_data.operation == OP_LOAD) &
                      (32'(in_data.slot) == i)) |
                     ((state == S_UPD) & (chosen == SW'(i)));
    assign load_data = (state == S_UPD) ? new_burst : in_data.burst;

    lsch_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctl       (ctl),
      .divisor   (div_eff),
      .load_en   (load_en),
      .load_data (load_data),
      .burst_in  (burst_ring[(i + 1) % SLOTS]),
      .tick_in   (tick_ring[(i + 1) % SLOTS]),
      .burst_out (burst_ring[i]),
      .tick_out  (tick_ring[i]),
      .nonzero   (nz[i])
    );
  end

  // ------------------------------------------------------ remainder unit
  lsch_mod #(
    .NUM_W (RAND_W),
    .DEN_W (TW)
  ) u_mod (
    .clk   (clk),
    .rst   (rst),
    .start (mod_start),
    .num   (rnd),
    .den   (total_next),
    .done  (mod_done),
    .rem   (win)
  );

  // ------------------------------------------------------------ sequencer
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_fire) begin
          state_next = (in_data.operation == OP_DRAW) ? S_DIV : S_OUT;
        end
      end
      S_DIV:  if (cnt == CNTW'(DIV_STEPS - 1)) state_next = S_FIX;
      S_FIX:  state_next = S_SUM;
      S_SUM: begin
        if (cnt == CNTW'(SLOTS - 1)) begin
          // no tickets anywhere: report an empty draw
          state_next = (total_next == '0) ? S_OUT : S_MOD;
        end
      end
      S_MOD:  if (mod_done) state_next = S_WALK;
      S_WALK: if (cnt == CNTW'(SLOTS - 1)) state_next = S_UPD;
      S_UPD:  state_next = S_OUT;
      S_OUT:  if (out_load) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Step counter for divider steps and ring passes; clear on phase change.
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (state_next != state) begin
      cnt <= '0;
    end else if ((state == S_DIV) | (state == S_SUM) | (state == S_WALK)) begin
      cnt <= cnt + CNTW'(1);
    end
  end

  // Datapath registers of the item in work.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_granted <= 1'b0;
      found       <= 1'b0;
    end else begin
      if (in_fire) begin
        res_granted <= 1'b0;
      end
      if (state == S_MOD) begin
        found <= 1'b0;
      end else if ((state == S_WALK) & hit) begin
        found <= 1'b1;
      end
      if (state == S_UPD) begin
        res_granted <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      rnd          <= in_data.random_value;
      chosen       <= '0;
      chosen_burst <= '0;
    end
    if (state == S_FIX) begin
      acc <= '0;
    end else if (state == S_SUM) begin
      acc <= total_next;
    end else if (state == S_MOD) begin
      acc <= '0;
    end else if (state == S_WALK) begin
      acc <= total_next;
      // capture the slot whose ticket range holds the winning ticket
      if (hit) begin
        chosen       <= cnt[SW-1:0];
        chosen_burst <= burst_ring[0];
      end
    end else if (state == S_UPD) begin
      chosen_burst <= new_burst;
    end
  end

  // --------------------------------------------------------- result stage
  assign slot_wide = {4'b0000, chosen};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (~out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data.winner_slot       <= res_granted ? slot_wide[SLOT_W-1:0] : '0;
      out_data.winner_burst_left <= res_granted ? chosen_burst : '0;
      out_data.granted           <= res_granted;
      out_data.all_done          <= ~(|nz);
    end
  end

endmodule

`default_nettype wire

[hdl/lsch_checker.sv]
// ----------------------------------------------------------------------------
// lsch_checker
// Port-level checks on the lottery scheduler, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module lsch_checker (
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                in_valid,
  input wire logic                in_stall,
  input wire logic                out_valid,
  input wire logic                out_stall,
  input wire lsch_pkg::out_item_t out_data
);
  import lsch_pkg::*;

  // A held result does not change until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // After a transfer in, the block is busy on the next clock.
  a_busy_after_in: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken twice in a row");

  // A result without a grant carries no winner.
  a_no_grant_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.granted |->
      out_data.winner_slot == '0 && out_data.winner_burst_left == '0)
    else $error("winner fields set without a grant");

  // A winner with burst left means the store is not empty.
  a_left_not_done: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.granted && out_data.winner_burst_left != '0 |->
      !out_data.all_done)
    else $error("all_done with burst remaining");

endmodule

bind lottery_scheduler_core lsch_checker u_lsch_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire
